// File: sv/json_comment_whitespace_stripper_top_assert.svh
// assertion macros for the json stripper checker
// clocked on clk_i, disabled while rst_ni is low
`ifndef JSON_COMMENT_WHITESPACE_STRIPPER_TOP_ASSERT_SVH
`define JSON_COMMENT_WHITESPACE_STRIPPER_TOP_ASSERT_SVH

// generic form with explicit clock and reset
`define JCWS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// default clock and reset of the checker
`define JCWS_ASSERT(lbl, prop, msg) \
  `JCWS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: sv/jcws_pkg.sv
// package for the json comment and whitespace stripper
// character codes, window state and result types, head evaluation function
package jcws_pkg;

  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;

  localparam int unsigned WinDepth   = 3;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [WinDepth-1:0][7:0] win;
    logic [1:0]               fill;
    logic [1:0]               skip;
    logic                     sq;
    logic                     dq;
    logic                     lc;
    logic                     bc;
  } win_state_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       end_of_text;
  } result_t;

  typedef struct packed {
    logic [1:0]                cnt;
    result_t [WinDepth-1:0]    res;
  } push_t;

  typedef struct packed {
    win_state_t st;
    logic       emit;
    logic [7:0] data;
  } head_t;

  function automatic logic is_line_end(logic [7:0] c);
    return (c == ChLf) || (c == ChCr) || (c == ChFf);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || is_line_end(c);
  endfunction

  // consume the oldest window byte; n is the count of real bytes in the window
  function automatic head_t take_head(win_state_t s, logic [1:0] n);
    head_t      h;
    logic [1:0] cur;
    logic [7:0] wc;
    logic [7:0] wc1;
    logic [7:0] c;
    h      = '0;
    h.st   = s;
    cur    = 2'd0;
    if (s.skip != 2'd0) begin
      h.st.skip = s.skip - 2'd1;
    end else begin
      if (!s.sq && !s.dq) begin
        if (s.win[0] == ChSlash && s.win[1] == ChSlash && !s.lc && !s.bc) begin
          h.st.lc = 1'b1;
        end else if (is_line_end(s.win[0]) && s.lc && !s.bc) begin
          cur     = 2'd1;
          h.st.lc = 1'b0;
        end
        wc  = cur[0] ? s.win[1] : s.win[0];
        wc1 = cur[0] ? s.win[2] : s.win[1];
        if (wc == ChSlash && wc1 == ChStar && !h.st.lc && !s.bc) begin
          h.st.bc = 1'b1;
        end else if (cur == 2'd0 && s.win[0] == ChStar && s.win[1] == ChSlash &&
                     !h.st.lc && s.bc) begin
          cur     = 2'd2;
          h.st.bc = 1'b0;
        end
      end
      h.st.skip = cur;
      c = s.win[cur];
      if (cur < n && !h.st.lc && !h.st.bc && !(is_blank(c) && !s.sq && !s.dq)) begin
        if (c == ChDquote && !s.sq) begin
          h.st.dq = !s.dq;
        end
        // single quote sees the double quote flag after its own toggle
        if (c == ChSquote && !h.st.dq) begin
          h.st.sq = !s.sq;
        end
        h.emit = 1'b1;
        h.data = c;
      end
    end
    h.st.win[0] = s.win[1];
    h.st.win[1] = s.win[2];
    h.st.win[2] = 8'h00;
    if (s.fill != 2'd0) begin
      h.st.fill = s.fill - 2'd1;
    end
    return h;
  endfunction

endpackage

// File: sv/jcws_if.sv
// valid/ready channel interfaces for the json stripper
// payload widths follow the text byte and result fields
interface jcws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       is_last;

  modport source (output valid, output byte_in, output is_last, input ready);
  modport sink (input valid, input byte_in, input is_last, output ready);
endinterface

interface jcws_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       byte_valid;
  logic       end_of_text;

  modport source (output valid, output byte_out, output byte_valid, output end_of_text,
                  input ready);
  modport sink (input valid, input byte_out, input byte_valid, input end_of_text,
                output ready);
endinterface

// File: sv/jcws_step.sv
// window and flag state with the per-byte strip logic
// depends on jcws_pkg for types and take_head
module jcws_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_in_i,
  input  logic                is_last_i,
  output jcws_pkg::push_t     push_o
);

  jcws_pkg::win_state_t st_q, st_d;
  jcws_pkg::win_state_t app;
  jcws_pkg::head_t      h0, h1, h2;
  logic [2:0]           em;
  logic [2:0][7:0]      dat;
  logic [1:0]           idx;
  jcws_pkg::push_t      push;

  always_comb begin
    app = st_q;
    app.win[st_q.fill] = byte_in_i;
    app.fill = st_q.fill + 2'd1;
    h0 = jcws_pkg::take_head(app, app.fill);
    h1 = jcws_pkg::take_head(h0.st, h0.st.fill);
    h2 = jcws_pkg::take_head(h1.st, h1.st.fill);
  end

  always_comb begin
    st_d = st_q;
    em   = '0;
    dat  = {h2.data, h1.data, h0.data};
    if (accept_i) begin
      if (is_last_i) begin
        // flush whatever remains, then start fresh text
        em[0] = h0.emit;
        em[1] = (h0.st.fill != 2'd0) && h1.emit;
        em[2] = (h1.st.fill != 2'd0) && h2.emit;
        st_d  = '0;
      end else if (app.fill == 2'd3) begin
        em[0] = h0.emit;
        st_d  = h0.st;
      end else begin
        st_d = app;
      end
    end
  end

  // pack the kept bytes into consecutive result slots
  always_comb begin
    push = '0;
    idx  = 2'd0;
    for (int k = 0; k < jcws_pkg::WinDepth; k++) begin
      if (em[k]) begin
        push.res[idx].byte_out   = dat[k];
        push.res[idx].byte_valid = 1'b1;
        idx = idx + 2'd1;
      end
    end
    if (accept_i && is_last_i) begin
      if (idx == 2'd0) begin
        push.res[0].end_of_text = 1'b1;
        idx = 2'd1;
      end else begin
        push.res[idx - 2'd1].end_of_text = 1'b1;
      end
    end
    push.cnt = idx;
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// File: sv/jcws_queue.sv
// four-entry result queue taking up to three results per transfer
// depends on jcws_pkg for the result and push types
module jcws_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jcws_pkg::push_t     push_i,
  input  logic                pop_i,
  output jcws_pkg::result_t   head_o,
  output logic                valid_o,
  output logic                room_o
);

  jcws_pkg::result_t mem_q [jcws_pkg::QueueDepth];
  logic [1:0]        wr_ptr_q, wr_ptr_d;
  logic [1:0]        rd_ptr_q, rd_ptr_d;
  logic [2:0]        cnt_q, cnt_d;

  assign valid_o = (cnt_q != 3'd0);
  // room for a full flush of three results
  assign room_o  = (cnt_q <= 3'd1);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.cnt;
    rd_ptr_d = rd_ptr_q + {1'b0, pop_i};
    cnt_d    = cnt_q + {1'b0, push_i.cnt} - {2'b00, pop_i};
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < jcws_pkg::WinDepth; k++) begin
      if (2'(k) < push_i.cnt) begin
        mem_q[wr_ptr_q + 2'(k)] <= push_i.res[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: sv/json_comment_whitespace_stripper_top.sv
// json stripper: the results of an input transfer enter a four-entry registered queue.
// throughput one byte per cycle while input is ready; a byte gives zero or one result,
// the final byte flushes the window and gives up to three results, leaving the queue
// one per cycle while the sink is ready. input is ready while at most one is queued.
// rst_ni (asynchronous, active low) clears the window, the quote and comment flags
// and the queue; after the final byte the state also returns to reset values.
module json_comment_whitespace_stripper_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  jcws_in_if.sink     in_ch_i,
  jcws_out_if.source  out_ch_o
);

  logic              accept;
  logic              pop;
  logic              room;
  logic              head_valid;
  jcws_pkg::push_t   push;
  jcws_pkg::result_t head;

  assign in_ch_i.ready = room;
  assign accept        = in_ch_i.valid && room;
  assign pop           = head_valid && out_ch_o.ready;

  jcws_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_in_i (in_ch_i.byte_in),
    .is_last_i (in_ch_i.is_last),
    .push_o    (push)
  );

  jcws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .room_o  (room)
  );

  assign out_ch_o.valid       = head_valid;
  assign out_ch_o.byte_out    = head.byte_out;
  assign out_ch_o.byte_valid  = head.byte_valid;
  assign out_ch_o.end_of_text = head.end_of_text;

endmodule

// File: sv/jcws_checker.sv
// port-level checks for the json stripper, bound to the top level
// depends on the assertion macro header
`include "json_comment_whitespace_stripper_top_assert.svh"

module jcws_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] byte_out_i,
  input logic       byte_valid_i,
  input logic       end_of_text_i
);

  `JCWS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `JCWS_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(byte_out_i), "result changed")
  `JCWS_ASSERT(a_empty_is_end, out_valid_i && !byte_valid_i |-> end_of_text_i, "empty result not final")
  `JCWS_ASSERT(a_empty_zero, out_valid_i && !byte_valid_i |-> byte_out_i == 8'h00, "empty result carries data")
  `JCWS_ASSERT(a_idle_ready, !out_valid_i |-> in_ready_i, "input stalled with no result pending")

endmodule

bind json_comment_whitespace_stripper_top jcws_checker u_jcws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_ch_i.ready),
  .out_valid_i   (out_ch_o.valid),
  .out_ready_i   (out_ch_o.ready),
  .byte_out_i    (out_ch_o.byte_out),
  .byte_valid_i  (out_ch_o.byte_valid),
  .end_of_text_i (out_ch_o.end_of_text)
);

// File: verif/json_comment_whitespace_stripper_top_tb.sv
// testbench for json_comment_whitespace_stripper_top: streams JSON-like texts, predicts the
// stripped output in-line and checks every result transfer; needs jcws_pkg and jcws_if
`timescale 1ns / 100ps

module json_comment_whitespace_stripper_top_tb;

  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned TextBudget = 400;
  localparam int unsigned EndCycles  = 20;

  typedef struct {
    logic [7:0]  ch;
    logic        last;
    bit          drain;
    int unsigned gap;
  } text_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_ready = 1'b0;

  jcws_in_if  in_ch ();
  jcws_out_if out_ch ();

  assign in_ch.valid   = in_valid;
  assign in_ch.byte_in = in_byte;
  assign in_ch.is_last = in_last;
  assign out_ch.ready  = out_ready;

  json_comment_whitespace_stripper_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_item_t          text_q[$];
  logic [7:0]          text_buf[$];
  jcws_pkg::result_t   stripped_q[$];

  int unsigned err_count       = 0;
  int unsigned bytes_sent      = 0;
  int unsigned texts_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned chars_kept      = 0;
  int unsigned idle_cycles     = 0;
  int unsigned cycle_cnt       = 0;
  int unsigned gap_left        = 0;
  int unsigned stall_left      = 0;

  // stripper state mirrored by the predictor
  logic [7:0]  win_q[3];
  int unsigned win_cnt  = 0;
  int unsigned skip_cnt = 0;
  bit          in_sq, in_dq, in_lc, in_bc;

  function automatic bit eol_char(logic [7:0] c);
    return c == jcws_pkg::ChLf || c == jcws_pkg::ChCr || c == jcws_pkg::ChFf;
  endfunction

  function automatic bit ws_char(logic [7:0] c);
    return c == jcws_pkg::ChSpace || c == jcws_pkg::ChTab || eol_char(c);
  endfunction

  task automatic clear_strip_state();
    win_q[0] = 8'h00;
    win_q[1] = 8'h00;
    win_q[2] = 8'h00;
    win_cnt  = 0;
    skip_cnt = 0;
    in_sq    = 1'b0;
    in_dq    = 1'b0;
    in_lc    = 1'b0;
    in_bc    = 1'b0;
  endtask

  // decide the head position; n counts the real bytes in the window
  task automatic eval_position(input int unsigned n, output bit kept,
                               output logic [7:0] ch);
    int unsigned cur;
    cur  = 0;
    kept = 1'b0;
    ch   = 8'h00;
    if (!in_sq && !in_dq) begin
      if (win_q[0] == jcws_pkg::ChSlash && win_q[1] == jcws_pkg::ChSlash &&
          !in_lc && !in_bc) begin
        in_lc = 1'b1;
      end else if (eol_char(win_q[0]) && in_lc && !in_bc) begin
        // newline closing a line comment is dropped with the shift
        cur   = 1;
        in_lc = 1'b0;
      end
      if (win_q[cur] == jcws_pkg::ChSlash && win_q[cur+1] == jcws_pkg::ChStar &&
          !in_lc && !in_bc) begin
        in_bc = 1'b1;
      end else if (cur == 0 && win_q[0] == jcws_pkg::ChStar &&
                   win_q[1] == jcws_pkg::ChSlash && !in_lc && in_bc) begin
        cur   = 2;
        in_bc = 1'b0;
      end
    end
    skip_cnt = cur;
    if (cur < n && !in_lc && !in_bc) begin
      ch = win_q[cur];
      if (!(ws_char(ch) && !in_sq && !in_dq)) begin
        if (ch == jcws_pkg::ChDquote && !in_sq) in_dq = !in_dq;
        if (ch == jcws_pkg::ChSquote && !in_dq) in_sq = !in_sq;
        kept = 1'b1;
      end
    end
    if (!kept) ch = 8'h00;
  endtask

  task automatic advance_window(input int unsigned n, output bit kept, output logic [7:0] ch);
    kept = 1'b0;
    ch   = 8'h00;
    if (skip_cnt > 0) begin
      skip_cnt--;
    end else begin
      eval_position(n, kept, ch);
    end
    win_q[0] = win_q[1];
    win_q[1] = win_q[2];
    win_q[2] = 8'h00;
    if (win_cnt > 0) win_cnt--;
  endtask

  task automatic predict_strip(input logic [7:0] b, input logic last);
    bit                kept;
    logic [7:0]        ch;
    logic [7:0]        flushed[3];
    int unsigned       produced;
    jcws_pkg::result_t r;
    produced = 0;
    win_q[win_cnt] = b;
    win_cnt++;
    if (!last) begin
      if (win_cnt == 3) begin
        advance_window(3, kept, ch);
        if (kept) begin
          r = '{byte_out: ch, byte_valid: 1'b1, end_of_text: 1'b0};
          stripped_q.push_back(r);
        end
      end
    end else begin
      while (win_cnt > 0) begin
        advance_window(win_cnt, kept, ch);
        if (kept) begin
          flushed[produced] = ch;
          produced++;
        end
      end
      if (produced == 0) begin
        r = '{byte_out: 8'h00, byte_valid: 1'b0, end_of_text: 1'b1};
        stripped_q.push_back(r);
      end else begin
        for (int i = 0; i < produced; i++) begin
          r = '{byte_out: flushed[i], byte_valid: 1'b1, end_of_text: (i == produced - 1)};
          stripped_q.push_back(r);
        end
      end
      clear_strip_state();
    end
  endtask

  task automatic report_error(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // mostly short idles, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 8))
      0:       return jcws_pkg::ChSlash;
      1:       return jcws_pkg::ChStar;
      2:       return jcws_pkg::ChDquote;
      3:       return jcws_pkg::ChSquote;
      4:       return jcws_pkg::ChLf;
      5:       return jcws_pkg::ChCr;
      6:       return jcws_pkg::ChFf;
      7:       return jcws_pkg::ChTab;
      default: return jcws_pkg::ChSpace;
    endcase
  endfunction

  function automatic logic [7:0] pick_text_char();
    if ($urandom_range(0, 3) == 0) return pick_special();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // moves the text being built into the pending stream, last byte marked
  task automatic flush_text(input bit calm, input bit drain);
    text_item_t it;
    for (int i = 0; i < text_buf.size(); i++) begin
      it.ch    = text_buf[i];
      it.last  = (i == text_buf.size() - 1);
      it.drain = drain && (i == 0);
      it.gap   = calm ? 0 : pick_gap();
      text_q.push_back(it);
    end
    text_buf.delete();
  endtask

  task automatic build_json_text();
    int unsigned tokens;
    tokens = $urandom_range(1, 8);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0: text_buf.push_back(pick_special());
        1: begin
          push_str("//");
          repeat ($urandom_range(0, 4)) text_buf.push_back(pick_text_char());
          case ($urandom_range(0, 2))
            0:       text_buf.push_back(jcws_pkg::ChLf);
            1:       text_buf.push_back(jcws_pkg::ChCr);
            default: text_buf.push_back(jcws_pkg::ChFf);
          endcase
        end
        2: begin
          push_str("/*");
          repeat ($urandom_range(0, 4)) text_buf.push_back(pick_text_char());
          push_str("*/");
        end
        3: begin
          text_buf.push_back(jcws_pkg::ChDquote);
          repeat ($urandom_range(0, 5)) text_buf.push_back(pick_text_char());
          text_buf.push_back(jcws_pkg::ChDquote);
        end
        4: begin
          text_buf.push_back(jcws_pkg::ChSquote);
          repeat ($urandom_range(0, 5)) text_buf.push_back(pick_text_char());
          text_buf.push_back(jcws_pkg::ChSquote);
        end
        5: begin
          case ($urandom_range(0, 5))
            0:       push_str("{");
            1:       push_str("}");
            2:       push_str("[");
            3:       push_str("]");
            4:       push_str(":");
            default: push_str(",");
          endcase
        end
        6: repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(8'h30, 8'h39)));
        7: push_str("\"key\" : 1");
        8: text_buf.push_back(8'($urandom_range(0, 255)));
        default: text_buf.push_back($urandom_range(0, 1) ? jcws_pkg::ChSlash : jcws_pkg::ChStar);
      endcase
    end
    // some texts are cut short, leaving comments or strings open
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        if (text_buf.size() > 1) void'(text_buf.pop_back());
      end
    end
  endtask

  // driver: predicts each byte at its transfer, then presents the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ch.ready) begin
        predict_strip(in_byte, in_last);
        bytes_sent++;
        if (in_last) texts_sent++;
      end
      if (!in_valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (text_q.size() > 0 && !(text_q[0].drain && stripped_q.size() != 0)) begin
          in_valid <= 1'b1;
          in_byte  <= text_q[0].ch;
          in_last  <= text_q[0].last;
          gap_left  = text_q[0].gap;
          void'(text_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, compares each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (out_ch.valid && out_ready) begin
        if (stripped_q.size() == 0) begin
          report_error($sformatf("unexpected result byte %02h valid %b end %b",
                                 out_ch.byte_out, out_ch.byte_valid, out_ch.end_of_text));
        end else begin
          results_checked++;
          if (stripped_q[0].byte_valid) chars_kept++;
          if (out_ch.byte_out !== stripped_q[0].byte_out)
            report_error($sformatf("byte_out %02h, predicted %02h",
                                   out_ch.byte_out, stripped_q[0].byte_out));
          if (out_ch.byte_valid !== stripped_q[0].byte_valid)
            report_error($sformatf("byte_valid %b, predicted %b",
                                   out_ch.byte_valid, stripped_q[0].byte_valid));
          if (out_ch.end_of_text !== stripped_q[0].end_of_text)
            report_error($sformatf("end_of_text %b, predicted %b",
                                   out_ch.end_of_text, stripped_q[0].end_of_text));
          void'(stripped_q.pop_front());
        end
      end
      // during part of each period of the cycle counter the sink runs without stalls
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = ((cycle_cnt % 512) < 128) ? 0 : pick_gap();
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ch.ready) || (out_ch.valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, stripped_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    bit calm;
    int unsigned texts_built;
    clear_strip_state();
    texts_built = 0;

    // directed texts: lone blank (nothing kept), zero and all-ones bytes,
    // slashes after a line-comment newline, slash star slash, quoted quote,
    // block close whose skip runs past the end
    push_str(" ");
    flush_text(1'b0, 1'b0);
    text_buf.push_back(8'h00);
    text_buf.push_back(8'hFF);
    flush_text(1'b1, 1'b0);
    push_str("//x\n//y");
    flush_text(1'b0, 1'b0);
    push_str("/*/a");
    flush_text(1'b1, 1'b0);
    text_buf.push_back(jcws_pkg::ChSquote);
    text_buf.push_back(jcws_pkg::ChDquote);
    text_buf.push_back(jcws_pkg::ChSquote);
    flush_text(1'b0, 1'b1);
    push_str("x/**/");
    flush_text(1'b0, 1'b0);

    while (text_q.size() < TextBudget) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 12)) begin
          text_buf.push_back($urandom_range(0, 1) ? pick_special() : 8'($urandom_range(0, 255)));
        end
      end else begin
        build_json_text();
      end
      calm = ($urandom_range(0, 3) == 0);
      // the first random text and some later ones wait for the output to drain
      flush_text(calm, texts_built == 0 || $urandom_range(0, 9) == 0);
      texts_built++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || in_valid || stripped_q.size() != 0) @(posedge clk_i);
    repeat (EndCycles) @(posedge clk_i);

    $display("streamed %0d bytes in %0d texts; checked %0d results, %0d kept characters",
             bytes_sent, texts_sent, results_checked, chars_kept);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", err_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
